// ===== design/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants for substring find and count
// Beat payload structs, configuration register map and cell control group.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int CHAR_BITS     = 8;
  localparam int REG_BYTES     = 8;   // pattern register holds 8 characters
  localparam int LEN_BITS      = 4;
  localparam int CFG_DATA_BITS = 64;
  localparam int ADDR_BITS     = 4;
  localparam int REG_SEL_BIT   = 3;   // registers sit on 8-byte boundaries
  localparam int OUT_BITS      = 16;

  // register select codes (paddr[REG_SEL_BIT])
  localparam logic REG_PATTERN = 1'b0;
  localparam logic REG_LENGTH  = 1'b1;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 is_last;
    logic                 has_char;
  } in_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] first_position;
    logic [OUT_BITS-1:0] match_count;
    logic                too_long;
  } out_item_t;

  typedef struct packed {
    logic shift;   // a character enters the window this cycle
    logic clear;   // string ended, window returns to zero
  } cell_ctrl_t;

endpackage

// ===== design/sfc_cell.sv =====
// ----------------------------------------------------------------------------
// sfc_cell: one window cell
// Holds one earlier character, passes it on to the next cell and folds its
// compare against the aligned pattern byte into the running match chain.
// ----------------------------------------------------------------------------
module sfc_cell
  import sfc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic [CHAR_BITS-1:0]     char_in,
  input  logic [LEN_BITS-1:0]      eff_len,
  input  logic [CFG_DATA_BITS-1:0] pattern,
  input  logic                     hit_in,
  output logic [CHAR_BITS-1:0]     char_out,
  output logic                     hit_out
);

  logic [LEN_BITS-1:0]  sel;
  logic                 active;
  logic [CHAR_BITS-1:0] pat_byte;

  // this cell holds the character IDX+1 places behind the newest one,
  // which lines up with pattern byte eff_len-2-IDX
  assign active   = eff_len >= LEN_BITS'(IDX + 2);
  assign sel      = eff_len - LEN_BITS'(IDX + 2);
  assign pat_byte = pattern[{sel[2:0], 3'b000} +: CHAR_BITS];
  assign hit_out  = hit_in & (!active | (char_out == pat_byte));

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      char_out <= '0;
    end else if (ctrl.shift) begin
      char_out <= char_in;
    end
  end

endmodule

// ===== design/substring_find_and_count.sv =====
// ----------------------------------------------------------------------------
// substring_find_and_count: streaming substring search with match count
// Compares a row of window cells against the pattern at every character and
// keeps the first match start and a greedy non-overlapping count.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle while the skid register is empty; the
//   count/allowed-start loop is combinational.
// The result is registered; while the output beat waits untaken, a new
//   result goes to a skid register and input keeps flowing; the input
//   stalls only while both result registers are full.
// Reset clears configuration, the window cells and all per-string counters.
module substring_find_and_count
  import sfc_pkg::*;
#(
  parameter int MAX_PATTERN = 8,
  parameter int POS_BITS    = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_BITS-1:0]     paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data
);

  localparam int WIN = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  logic [CFG_DATA_BITS-1:0] pattern_bytes;
  logic [LEN_BITS-1:0]      pattern_length;
  logic [LEN_BITS-1:0]      eff_len;
  logic                     cfg_write;

  logic [POS_BITS-1:0] char_position;
  logic [POS_BITS:0]   next_allowed_start;
  logic [POS_BITS-1:0] first_found;
  logic [POS_BITS-1:0] running_count;
  logic                overflow_seen;

  logic                char_position_next_en;
  logic [POS_BITS-1:0] pos_inc;
  logic [POS_BITS-1:0] start;
  logic [POS_BITS-1:0] len_ext;
  logic [POS_BITS:0]   next_allowed_start_next;
  logic [POS_BITS-1:0] first_found_next;
  logic [POS_BITS-1:0] running_count_next;
  logic                overflow_seen_next;
  logic                accept;
  logic                at_max;
  logic                take;
  logic                match;
  logic                counted;
  logic [LEN_BITS-1:0] cur_sel;

  out_item_t result_next;
  logic      skid_valid;
  out_item_t skid_data;

  cell_ctrl_t           ctrl;
  logic [CHAR_BITS-1:0] char_chain [WIN+1];
  logic                 hit_chain  [WIN+1];

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
    end else if (cfg_write) begin
      case (paddr[REG_SEL_BIT])
        REG_PATTERN: pattern_bytes  <= pwdata;
        REG_LENGTH:  pattern_length <= pwdata[LEN_BITS-1:0];
        default:     pattern_bytes  <= pattern_bytes;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_PATTERN: prdata = pattern_bytes;
      REG_LENGTH:  prdata = CFG_DATA_BITS'(pattern_length);
      default:     prdata = '0;
    endcase
  end

  assign eff_len = (pattern_length > LEN_BITS'(WIN)) ? LEN_BITS'(WIN) : pattern_length;

  // ---------------------------------------------------------------- handshake
  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign at_max   = char_position == POS_MAX;
  assign take     = accept && in_data.has_char && !at_max;

  assign ctrl.shift = take;
  assign ctrl.clear = accept && in_data.is_last;

  // ---------------------------------------------------------------- cell row
  // newest character meets the last pattern byte before entering the row
  assign cur_sel       = eff_len - LEN_BITS'(1);
  assign char_chain[0] = in_data.char_code;
  assign hit_chain[0]  = in_data.char_code == pattern_bytes[{cur_sel[2:0], 3'b000} +: CHAR_BITS];

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    sfc_cell #(
      .IDX(k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .char_in (char_chain[k]),
      .eff_len (eff_len),
      .pattern (pattern_bytes),
      .hit_in  (hit_chain[k]),
      .char_out(char_chain[k+1]),
      .hit_out (hit_chain[k+1])
    );
  end

  // ---------------------------------------------------------------- counting
  assign pos_inc = char_position + 1'b1;
  assign len_ext = POS_BITS'(eff_len);
  assign start   = pos_inc - len_ext + 1'b1;
  assign match   = take && (eff_len != '0) && (pos_inc >= len_ext) && hit_chain[WIN];
  assign counted = match && ({1'b0, start} >= next_allowed_start);

  assign char_position_next_en = take;
  assign first_found_next   = (match && first_found == '0) ? start : first_found;
  assign running_count_next = (counted && running_count != POS_MAX) ?
                              running_count + 1'b1 : running_count;
  assign next_allowed_start_next = counted ? {1'b0, pos_inc} + 1'b1 : next_allowed_start;
  assign overflow_seen_next = overflow_seen | (accept && in_data.has_char && at_max);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      char_position      <= '0;
      next_allowed_start <= '0;
      first_found        <= '0;
      running_count      <= '0;
      overflow_seen      <= 1'b0;
    end else if (accept) begin
      if (char_position_next_en) begin
        char_position <= pos_inc;
      end
      next_allowed_start <= next_allowed_start_next;
      first_found        <= first_found_next;
      running_count      <= running_count_next;
      overflow_seen      <= overflow_seen_next;
    end
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    if (eff_len == '0) begin
      result_next.first_position = OUT_BITS'(1);
      result_next.match_count    = '0;
    end else begin
      result_next.first_position = OUT_BITS'(first_found_next);
      result_next.match_count    = OUT_BITS'(running_count_next);
    end
    result_next.too_long = overflow_seen_next;
  end

  // skid holds a second result while the output beat waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (ctrl.clear) begin
        out_valid <= 1'b1;
        out_data  <= result_next;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (ctrl.clear) begin
      skid_valid <= 1'b1;
      skid_data  <= result_next;
    end
  end

  // ---------------------------------------------------------------- checks
  a_count_has_first : assert property (@(posedge clk) disable iff (rst)
    running_count != '0 |-> first_found != '0)
    else $error("match counted without a first match start");

  a_overflow_saturated : assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> char_position == POS_MAX)
    else $error("overflow flagged while position not saturated");

  a_allowed_start_bound : assert property (@(posedge clk) disable iff (rst)
    next_allowed_start <= {1'b0, char_position} + 1'b1)
    else $error("allowed start runs ahead of position");

  a_end_of_string : assert property (@(posedge clk) disable iff (rst)
    accept && in_data.is_last |=> out_valid && char_chain[WIN] == '0)
    else $error("string end did not raise a result or clear the window");

endmodule

// ===== bench/substring_find_and_count_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_find_and_count_tb: self-checking bench for substring find/count
// Drives subject strings under several pattern settings and idle patterns,
// predicts first match position and non-overlapping count per string, and
// checks every result beat against the prediction in order.
// ----------------------------------------------------------------------------
module substring_find_and_count_tb;
  import sfc_pkg::*;

  localparam int MAX_PAT      = 8;
  localparam int POS_LIMIT    = 65535;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_CHARS  = 72;
  localparam int NUM_PHASES   = 8;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_BITS-1:0]     paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  in_item_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_data;

  substring_find_and_count DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // predictor copy of configuration and per-string state
  logic [CFG_DATA_BITS-1:0] pat_reg = '0;
  logic [LEN_BITS-1:0]      len_reg = '0;
  logic [CHAR_BITS-1:0]     hist [REG_BYTES];
  logic [OUT_BITS-1:0]      char_pos = '0;
  logic [OUT_BITS:0]        allow_start = '0;
  logic [OUT_BITS-1:0]      first_hit = '0;
  logic [OUT_BITS-1:0]      hit_count = '0;
  logic                     overrun = 1'b0;

  in_item_t  pending_chars[$];
  out_item_t pending_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    foreach (hist[k]) hist[k] = '0;
  end

  function automatic int eff_len();
    int n;
    n = int'(len_reg);
    if (n > MAX_PAT) n = MAX_PAT;
    if (n > REG_BYTES) n = REG_BYTES;
    return n;
  endfunction

  task automatic absorb_char(input logic [CHAR_BITS-1:0] c);
    int n;
    int back;
    bit hit;
    logic [CHAR_BITS-1:0] ch;
    logic [OUT_BITS-1:0] start;
    n = eff_len();
    if (char_pos == OUT_BITS'(POS_LIMIT)) begin
      overrun = 1'b1;
      return;
    end
    char_pos = char_pos + 1'b1;
    hit = (n > 0) && (int'(char_pos) >= n);
    for (int j = 0; j < n; j++) begin
      back = n - 1 - j;
      ch = (back == 0) ? c : hist[back-1];
      if (ch != pat_reg[8*j +: 8]) hit = 1'b0;
    end
    if (hit) begin
      start = char_pos - OUT_BITS'(n) + 1'b1;
      if (first_hit == '0) first_hit = start;
      if ({1'b0, start} >= allow_start) begin
        if (hit_count != OUT_BITS'(POS_LIMIT)) hit_count = hit_count + 1'b1;
        allow_start = {1'b0, char_pos} + 1'b1;
      end
    end
    for (int k = REG_BYTES - 1; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = c;
  endtask

  task automatic predict_beat(input in_item_t it);
    out_item_t r;
    if (it.has_char) absorb_char(it.char_code);
    if (it.is_last) begin
      r.too_long = overrun;
      if (eff_len() == 0) begin
        r.first_position = OUT_BITS'(1);
        r.match_count = '0;
      end else begin
        r.first_position = first_hit;
        r.match_count = hit_count;
      end
      pending_results.push_back(r);
      foreach (hist[k]) hist[k] = '0;
      char_pos = '0;
      allow_start = '0;
      first_hit = '0;
      hit_count = '0;
      overrun = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result beat, first_position",
                      int'(got.first_position), 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.first_position !== want.first_position)
      report_mismatch("first_position", int'(got.first_position),
                      int'(want.first_position));
    if (got.match_count !== want.match_count)
      report_mismatch("match_count", int'(got.match_count), int'(want.match_count));
    if (got.too_long !== want.too_long)
      report_mismatch("too_long", int'(got.too_long), int'(want.too_long));
  endtask

  // input driver: holds a beat until taken, then maybe idles
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) predict_beat(in_data);
      if (!in_valid || in_ready) begin
        if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_chars.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] timeout: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic sel, input logic [CFG_DATA_BITS-1:0] val);
    logic [ADDR_BITS-1:0] a;
    a = '0;
    a[REG_SEL_BIT] = sel;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_PATTERN) pat_reg = val;
    else len_reg = val[LEN_BITS-1:0];
  endtask

  task automatic load_pattern(input logic [CFG_DATA_BITS-1:0] bytes,
                              input logic [LEN_BITS-1:0] len);
    write_reg(REG_PATTERN, bytes);
    write_reg(REG_LENGTH, CFG_DATA_BITS'(len));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_chars.size() != 0 || in_valid || pending_results.size() != 0);
    // a no-result beat may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic push_beat(input logic [CHAR_BITS-1:0] c, input logic last,
                           input logic has);
    in_item_t b;
    b.char_code = c;
    b.is_last = last;
    b.has_char = has;
    pending_chars.push_back(b);
  endtask

  task automatic push_text(input string s);
    if (s.len() == 0) push_beat(8'h00, 1'b1, 1'b0);
    for (int i = 0; i < s.len(); i++) push_beat(s[i], i == s.len() - 1, 1'b1);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
      default: begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  // mostly pattern pieces and pattern characters so matches are common
  task automatic push_random_subject(output int n_chars);
    in_item_t b;
    int n;
    int want_len;
    int r;
    logic [CHAR_BITS-1:0] c;
    n = eff_len();
    want_len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 16);
    n_chars = 0;
    while (n_chars < want_len) begin
      r = $urandom_range(99);
      if (r < 5) begin
        push_beat(CHAR_BITS'($urandom_range(255)), 1'b0, 1'b0);
      end else if (r < 30 && n > 0) begin
        for (int j = 0; j < n; j++) push_beat(pat_reg[8*j +: 8], 1'b0, 1'b1);
        n_chars += n;
      end else begin
        if (n > 0 && $urandom_range(9) < 7) c = pat_reg[8*$urandom_range(n - 1) +: 8];
        else c = CHAR_BITS'($urandom_range(255));
        push_beat(c, 1'b0, 1'b1);
        n_chars++;
      end
    end
    if (n_chars == 0 || $urandom_range(6) == 0) begin
      push_beat(CHAR_BITS'($urandom_range(255)), 1'b1, 1'b0);
    end else begin
      b = pending_chars.pop_back();
      b.is_last = 1'b1;
      pending_chars.push_back(b);
    end
  endtask

  initial begin
    logic [CFG_DATA_BITS-1:0] pb;
    logic [LEN_BITS-1:0] ln;
    int got;
    int phase_chars;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty pattern straight out of reset
    push_text("");
    push_text("xy");
    wait_drained();

    // overlapping candidates, ignored beat mid-string, short subjects
    load_pattern(64'h6161, 4'd2);
    push_beat("a", 1'b0, 1'b1);
    push_beat("a", 1'b0, 1'b1);
    push_beat(8'hA5, 1'b0, 1'b0);
    push_text("aaa");
    push_text("");
    push_text("a");
    wait_drained();

    // full-width pattern of all ones, ended by a characterless last beat
    load_pattern({CFG_DATA_BITS{1'b1}}, 4'd8);
    repeat (8) push_beat(8'hFF, 1'b0, 1'b1);
    push_beat(8'h00, 1'b0, 1'b1);
    push_beat(8'h00, 1'b1, 1'b0);
    wait_drained();

    // length above the register capacity acts as eight
    load_pattern('0, 4'd15);
    repeat (7) push_beat(8'h00, 1'b0, 1'b1);
    push_beat(8'h00, 1'b1, 1'b1);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int j = 0; j < REG_BYTES; j++)
        pb[8*j +: 8] = ($urandom_range(9) == 0) ? CHAR_BITS'($urandom_range(255))
                                                : 8'h61 + CHAR_BITS'($urandom_range(3));
      ln = ($urandom_range(4) == 0) ? LEN_BITS'($urandom_range(15))
                                    : LEN_BITS'($urandom_range(1, 8));
      load_pattern(pb, ln);
      set_idle(p % 4);
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) begin
        push_random_subject(got);
        phase_chars += got;
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sfc_pkg.sv
design/sfc_cell.sv
design/substring_find_and_count.sv
bench/substring_find_and_count_tb.sv
